>>> rtl/core/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared widths, limits, codes and clamp functions of the sprite animation
// sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam int MAX_FRAMES    = 4096;
	localparam int MAX_CELL_SIZE = 4096;

	localparam int FRAME_W  = 12;
	localparam int TIME_W   = 16;
	localparam int TIMER_W  = 40;
	localparam int PERIOD_W = 32;
	localparam int COLS_W   = 11;
	localparam int CELL_W   = 13;
	localparam int LEFT_W   = 22;
	localparam int TOP_W    = 24;
	localparam int RIGHT_W  = 23;
	localparam int BOTTOM_W = 25;
	localparam int PROD_W   = FRAME_W + CELL_W;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam int COLS_MAX  = 1024;
	localparam int DIV_STEPS = FRAME_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_FRAME   = 4'd0,
		REG_LAST_FRAME    = 4'd1,
		REG_FRAME_PERIOD  = 4'd2,
		REG_SHEET_COLUMNS = 4'd3,
		REG_CELL_WIDTH    = 4'd4,
		REG_CELL_HEIGHT   = 4'd5,
		REG_LOOP_ENABLE   = 4'd6,
		REG_STEP_MODE     = 4'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_CMP,
		S_ADV,
		S_DIV,
		S_DIV_WAIT,
		S_MUL_L,
		S_SUM_L,
		S_SUM_T,
		S_OUT
	} seq_state_t;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SET  = 1'b1;

	function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_W-1:0] v);
		logic [COLS_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = COLS_W'(1);
		end else if (int'(v) > COLS_MAX) begin
			r = COLS_W'(COLS_MAX);
		end
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] clamp_cell(input logic [CELL_W-1:0] v);
		logic [CELL_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CELL_W'(1);
		end else if (int'(v) > MAX_CELL_SIZE) begin
			r = CELL_W'(MAX_CELL_SIZE);
		end
		return r;
	endfunction

	function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] v);
		logic [FRAME_W-1:0] r;
		r = v;
		if (int'(v) >= MAX_FRAMES) begin
			r = FRAME_W'(MAX_FRAMES - 1);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/sas_divider.sv
// ----------------------------------------------------------------------------
// sas_divider
// Restoring divider, one quotient bit per cycle: frame index by column count.
// ----------------------------------------------------------------------------
module sas_divider import sas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [FRAME_W-1:0] dividend,
	input  logic [COLS_W-1:0]  divisor,
	output logic [FRAME_W-1:0] quotient,
	output logic [COLS_W-1:0]  remainder,
	output logic               done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FRAME_W-1:0]   quo_q;
	logic [COLS_W-1:0]    rem_q;
	logic [COLS_W:0]      trial;
	logic [COLS_W:0]      diff;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	assign trial = {rem_q, quo_q[FRAME_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[FRAME_W-2:0], fits};
			rem_q <= fits ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

>>> rtl/core/sprite_animation_sequencer_core.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_core
// Sprite sheet frame sequencer: timer, frame stepping and cell rectangle.
// ----------------------------------------------------------------------------
// A set, or a tick while last_frame is not above first_frame, goes straight to
// the divider; any other tick adds the elapsed time, compares it with the period
// and, if greater, advances the frame. Requests are taken one at a time, the time
// per request set mainly by the 12-step column divider and the shared multiplier used once for left, once for top.
// Reset: frame, timer and done clear, registers return to their reset values.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_core import sas_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  action,
	input  logic [TIME_W-1:0]     elapsed_time,
	input  logic [FRAME_W-1:0]    new_frame,

	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [FRAME_W-1:0]    frame_index,
	output logic [LEFT_W-1:0]     rect_left,
	output logic [TOP_W-1:0]      rect_top,
	output logic [RIGHT_W-1:0]    rect_right,
	output logic [BOTTOM_W-1:0]   rect_bottom,
	output logic                  done_flag
);

	// Configuration registers.
	logic [FRAME_W-1:0]  first_q;
	logic [FRAME_W-1:0]  last_q;
	logic [PERIOD_W-1:0] period_q;
	logic [COLS_W-1:0]   cols_q;
	logic [CELL_W-1:0]   width_q;
	logic [CELL_W-1:0]   height_q;
	logic                loop_q;
	logic                mode_q;

	// Sequencer state.
	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [FRAME_W-1:0]  frame_q;
	logic [TIMER_W-1:0]  timer_q;
	logic                done_q;
	logic [TIME_W-1:0]   elapsed_q;

	// Datapath.
	logic                accept;
	logic                out_free;
	logic                div_start;
	logic                div_done;
	logic [FRAME_W-1:0]  div_quo;
	logic [COLS_W-1:0]   div_rem;
	logic [FRAME_W-1:0]  mul_a;
	logic [CELL_W-1:0]   mul_b;
	logic [PROD_W-1:0]   prod_q;
	logic [LEFT_W-1:0]   left_q;
	logic [RIGHT_W-1:0]  right_q;
	logic [TOP_W-1:0]    top_q;
	logic [BOTTOM_W-1:0] bottom_q;
	logic [TIMER_W:0]    timer_sum;
	logic [TIMER_W:0]    timer_diff;
	logic                timer_over;
	logic [FRAME_W:0]    next_frame;
	logic                next_out;
	logic                load_result;
	logic                result_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			last_q   <= '0;
			period_q <= PERIOD_W'(65536);
			cols_q   <= COLS_W'(1);
			width_q  <= CELL_W'(2);
			height_q <= CELL_W'(2);
			loop_q   <= 1'b1;
			mode_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_FRAME:   first_q  <= cfg_data[FRAME_W-1:0];
				REG_LAST_FRAME:    last_q   <= cfg_data[FRAME_W-1:0];
				REG_FRAME_PERIOD:  period_q <= cfg_data[PERIOD_W-1:0];
				REG_SHEET_COLUMNS: cols_q   <= clamp_cols(cfg_data[COLS_W-1:0]);
				REG_CELL_WIDTH:    width_q  <= clamp_cell(cfg_data[CELL_W-1:0]);
				REG_CELL_HEIGHT:   height_q <= clamp_cell(cfg_data[CELL_W-1:0]);
				REG_LOOP_ENABLE:   loop_q   <= cfg_data[0];
				REG_STEP_MODE:     mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept   = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	// Timer add saturates at the full timer width.
	assign timer_sum  = {1'b0, timer_q} + (TIMER_W + 1)'(elapsed_q);
	// The period is taken out only when the timer is strictly greater.
	assign timer_diff = {1'b0, timer_q} - (TIMER_W + 1)'(period_q);
	assign timer_over = !timer_diff[TIMER_W] && (timer_diff[TIMER_W-1:0] != '0);

	assign next_frame = {1'b0, frame_q} + (mode_q ? (FRAME_W + 1)'(cols_q) : (FRAME_W + 1)'(1));
	assign next_out   = (next_frame < {1'b0, first_q}) || (next_frame > {1'b0, last_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_SET || last_q <= first_q) begin
						state_d = S_DIV;
					end else begin
						state_d = S_ADD;
					end
				end
			end
			S_ADD:      state_d = S_CMP;
			S_CMP:      state_d = timer_over ? S_ADV : S_DIV;
			S_ADV:      state_d = S_DIV;
			S_DIV:      state_d = S_DIV_WAIT;
			S_DIV_WAIT: state_d = div_done ? S_MUL_L : S_DIV_WAIT;
			S_MUL_L:    state_d = S_SUM_L;
			S_SUM_L:    state_d = S_SUM_T;
			S_SUM_T:    state_d = S_OUT;
			S_OUT:      state_d = out_free ? S_IDLE : S_OUT;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_stall  = (state_q != S_IDLE);
		div_start   = (state_q == S_DIV);
		load_result = (state_q == S_OUT) && out_free;
		mul_a       = (state_q == S_SUM_L) ? div_quo : FRAME_W'(div_rem);
		mul_b       = (state_q == S_SUM_L) ? height_q : width_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			frame_q <= '0;
			timer_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && action == ACT_SET) begin
				frame_q <= clamp_frame(new_frame);
				timer_q <= '0;
				done_q  <= 1'b0;
			end else if (state_q == S_ADD) begin
				timer_q <= timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
			end else if (state_q == S_CMP && timer_over) begin
				timer_q <= timer_diff[TIMER_W-1:0];
			end else if (state_q == S_ADV) begin
				if (!next_out) begin
					frame_q <= next_frame[FRAME_W-1:0];
				end else if (loop_q) begin
					frame_q <= first_q;
				end else begin
					frame_q <= last_q;
					done_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q <= elapsed_time;
		end
		if (state_q == S_MUL_L || state_q == S_SUM_L) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (state_q == S_SUM_L) begin
			left_q  <= prod_q[LEFT_W-1:0];
			right_q <= RIGHT_W'(prod_q + PROD_W'(width_q));
		end
		if (state_q == S_SUM_T) begin
			top_q    <= prod_q[TOP_W-1:0];
			bottom_q <= BOTTOM_W'(prod_q + PROD_W'(height_q));
		end
	end

	sas_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (frame_q),
		.divisor   (cols_q),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	// Result register: holds one finished request while the next is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			frame_index <= frame_q;
			rect_left   <= left_q;
			rect_top    <= top_q;
			rect_right  <= right_q;
			rect_bottom <= bottom_q;
			done_flag   <= done_q;
		end
	end

	assign result_valid = result_valid_q;

endmodule
